/* rtl/core/u8d_pkg.sv */
package u8d_pkg;

   // Widths of the item fields.
   localparam int ByteWidth = 8;
   localparam int CpWidth   = 31;
   localparam int LeftWidth = 3;

   // Lead-byte thresholds that select the sequence length.
   localparam logic [ByteWidth-1:0] AsciiLimit = 8'h80;
   localparam logic [ByteWidth-1:0] Lead3Limit = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead4Limit = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead5Limit = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead6Limit = 8'hFC;

   // Payload masks for lead and continuation bytes.
   localparam logic [ByteWidth-1:0] ContMask  = 8'h3F;
   localparam logic [ByteWidth-1:0] Lead2Mask = 8'h1F;
   localparam logic [ByteWidth-1:0] Lead3Mask = 8'h0F;
   localparam logic [ByteWidth-1:0] Lead4Mask = 8'h07;
   localparam logic [ByteWidth-1:0] Lead5Mask = 8'h03;
   localparam logic [ByteWidth-1:0] Lead6Mask = 8'h01;

   // Continuation counts; three or more left means a 4- to 6-byte sequence.
   localparam logic [LeftWidth-1:0] WideLeftMin = 3'd3;

   // Decoder state carried from one item to the next.
   typedef struct packed {
      logic [LeftWidth-1:0] bytes_left;
      logic [CpWidth-1:0]   partial_value;
      logic                 suppress_current;
   } dec_state_type;

   // Outcome of one decode step.
   typedef struct packed {
      logic               emit;
      logic               has_char;
      logic               last;
      logic [CpWidth-1:0] code_point;
   } dec_result_type;

endpackage

/* rtl/core/utf8_stream_decoder.sv */
// A result item goes from the input register to the result register, which drives rsp_valid.
// Throughput: one byte per cycle while no held result stalls the input; the input register
// and the result register each hold one item; the decode step between them is combinational.
// A byte that yields no item leaves the input register in the next cycle; a held result item
// keeps the next producing byte in the input register and drops req_ready until it is taken.
// Reset clears the decoder state and both stage valids, and sets wide_output to 1.
module utf8_stream_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [u8d_pkg::ByteWidth-1:0] req_text_byte,
   input  logic                          req_end_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u8d_pkg::CpWidth-1:0]   rsp_code_point,
   output logic                          rsp_has_char,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);
   import u8d_pkg::*;

   logic                 wide_ff, wide_in;
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;
   dec_state_type        state_ff, state_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CpWidth-1:0]   out_cp_ff;
   logic                 out_has_ff;
   logic                 out_last_ff;
   dec_result_type       step_result;
   logic                 advance;
   logic                 take_in;

   // Decode step for the item held in the input register.
   u8d_step u_step (
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .wide_output (wide_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .result      (step_result)
   );

   // The held item moves on when it yields nothing or the result register is free.
   assign advance   = in_valid_ff && (!step_result.emit || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_in   = req_valid && req_ready;

   assign in_valid_in  = take_in || (in_valid_ff && !advance);
   assign out_valid_in = (advance && step_result.emit) || (out_valid_ff && !rsp_ready);
   assign wide_in      = csr_wr_en ? csr_wr_data : wide_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff      <= 1'b1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         wide_ff      <= wide_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_end_of_text;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance && step_result.emit) begin
         out_cp_ff   <= step_result.code_point;
         out_has_ff  <= step_result.has_char;
         out_last_ff <= step_result.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_has_char   = out_has_ff;
   assign rsp_last       = out_last_ff;

endmodule

/* rtl/core/u8d_step.sv */
module u8d_step (
   input  logic [u8d_pkg::ByteWidth-1:0] text_byte,
   input  logic                          end_of_text,
   input  logic                          wide_output,
   input  u8d_pkg::dec_state_type        state_cur,
   output u8d_pkg::dec_state_type        state_nxt,
   output u8d_pkg::dec_result_type       result
);
   import u8d_pkg::*;

   logic [ByteWidth-1:0] lead_mask;
   logic [LeftWidth-1:0] lead_left;
   logic [CpWidth-1:0]   shifted;
   logic                 have;
   logic [CpWidth-1:0]   cp;
   dec_state_type        step_state;

   // Sequence length and lead payload mask from the lead byte.
   always_comb begin
      if (text_byte < Lead3Limit) begin
         lead_left = 3'd1;
         lead_mask = Lead2Mask;
      end else if (text_byte < Lead4Limit) begin
         lead_left = 3'd2;
         lead_mask = Lead3Mask;
      end else if (text_byte < Lead5Limit) begin
         lead_left = 3'd3;
         lead_mask = Lead4Mask;
      end else if (text_byte < Lead6Limit) begin
         lead_left = 3'd4;
         lead_mask = Lead5Mask;
      end else begin
         lead_left = 3'd5;
         lead_mask = Lead6Mask;
      end
   end

   // Append six payload bits of a continuation byte.
   assign shifted = {state_cur.partial_value[CpWidth-7:0], text_byte[5:0] & ContMask[5:0]};

   // One decode step: pass an ASCII byte through, or start, extend or finish a sequence.
   always_comb begin
      have       = 1'b0;
      cp         = '0;
      step_state = state_cur;
      if (state_cur.bytes_left == '0) begin
         if (text_byte < AsciiLimit) begin
            have = 1'b1;
            cp   = {{(CpWidth-ByteWidth){1'b0}}, text_byte};
         end else begin
            step_state.bytes_left       = lead_left;
            step_state.partial_value    = {{(CpWidth-ByteWidth){1'b0}}, text_byte & lead_mask};
            step_state.suppress_current = (lead_left >= WideLeftMin) && !wide_output;
         end
      end else begin
         step_state.bytes_left    = state_cur.bytes_left - 3'd1;
         step_state.partial_value = shifted;
         if (state_cur.bytes_left == 3'd1) begin
            have                        = !state_cur.suppress_current;
            cp                          = state_cur.suppress_current ? '0 : shifted;
            step_state.partial_value    = '0;
            step_state.suppress_current = 1'b0;
         end
      end
   end

   // The final byte of a text always clears the state and always yields an item.
   always_comb begin
      state_nxt = end_of_text ? '0 : step_state;
      result.emit       = have || end_of_text;
      result.has_char   = have;
      result.last       = end_of_text;
      result.code_point = cp;
   end

endmodule

/* bench/utf8_stream_decoder_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

   import u8d_pkg::*;

   // One decoded character item as it should leave the block.
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               has_char;
      logic               is_last;
   } char_item_type;

   // Cycles from acceptance of a byte to its result item, plus margin.
   localparam int DrainCycles = 6;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ByteWidth-1:0] req_text_byte = '0;
   logic                 req_end_of_text = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CpWidth-1:0]   rsp_code_point;
   logic                 rsp_has_char;
   logic                 rsp_last;
   logic                 csr_wr_en = 1'b0;
   logic                 csr_wr_data = 1'b0;

   // Decoder state mirrored on the bench side.
   logic                 wide_en = 1'b1;
   logic [LeftWidth-1:0] cont_left = '0;
   logic [CpWidth-1:0]   gathered_bits = '0;
   logic                 drop_seq = 1'b0;

   char_item_type expected_chars[$];
   int                 err_cnt = 0;
   logic               idle_on = 1'b0;

   utf8_stream_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_has_char    (rsp_has_char),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Decodes one byte into the mirrored state; returns 1 when an item is due.
   function automatic logic decode_byte(input logic [ByteWidth-1:0] b, input logic fin,
                                        output char_item_type item);
      logic               got_char;
      logic [CpWidth-1:0] value;
      got_char = 1'b0;
      value    = '0;
      if (cont_left == 0) begin
         if (b < AsciiLimit) begin
            got_char = 1'b1;
            value    = CpWidth'(b);
         end else begin
            if (b < Lead3Limit) begin
               cont_left     = 3'd1;
               gathered_bits = CpWidth'(b & Lead2Mask);
            end else if (b < Lead4Limit) begin
               cont_left     = 3'd2;
               gathered_bits = CpWidth'(b & Lead3Mask);
            end else if (b < Lead5Limit) begin
               cont_left     = 3'd3;
               gathered_bits = CpWidth'(b & Lead4Mask);
            end else if (b < Lead6Limit) begin
               cont_left     = 3'd4;
               gathered_bits = CpWidth'(b & Lead5Mask);
            end else begin
               cont_left     = 3'd5;
               gathered_bits = CpWidth'(b & Lead6Mask);
            end
            drop_seq = (cont_left >= WideLeftMin) && !wide_en;
         end
      end else begin
         gathered_bits = {gathered_bits[CpWidth-7:0], b[5:0]};
         cont_left     = cont_left - 3'd1;
         if (cont_left == 0) begin
            if (!drop_seq) begin
               got_char = 1'b1;
               value    = gathered_bits;
            end
            gathered_bits = '0;
            drop_seq      = 1'b0;
         end
      end
      // The final byte closes the text whatever was open.
      if (fin) begin
         cont_left     = '0;
         gathered_bits = '0;
         drop_seq      = 1'b0;
      end
      item.code_point = got_char ? value : '0;
      item.has_char   = got_char;
      item.is_last    = fin;
      return got_char || fin;
   endfunction

   // Sends one byte item, with random idle cycles ahead of it when idling is on.
   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic fin);
      char_item_type item;
      while (idle_on && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= fin;
      do @(posedge clock); while (!req_ready);
      if (decode_byte(b, fin, item)) begin
         expected_chars.push_back(item);
      end
   endtask

   // Lets every item in flight come out, then waits out the pipeline.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_wide(input logic value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      wide_en      = value;
   endtask

   // Result side: random stalls when idling is on.
   always @(posedge clock) begin
      if (idle_on) begin
         rsp_ready <= ($urandom_range(0, 99) >= 38);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic note_mismatch(input string what, input char_item_type want);
      if (err_cnt < 10) begin
         $display("%0t: %s: expected cp=%h has_char=%b last=%b, got cp=%h has_char=%b last=%b",
                  $time, what, want.code_point, want.has_char, want.is_last,
                  rsp_code_point, rsp_has_char, rsp_last);
      end
      err_cnt++;
   endtask

   // Each accepted result item is compared with the oldest expected one.
   always @(posedge clock) begin
      char_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            want = '0;
            note_mismatch("item with none expected", want);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_code_point !== want.code_point || rsp_has_char !== want.has_char ||
                rsp_last !== want.is_last) begin
               note_mismatch("wrong item", want);
            end
         end
      end
   end

   // Plain ASCII bytes, including the zero byte.
   task automatic test_single_bytes;
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // One sequence of each length from two to six bytes; the first four lead bytes sit at the edges of their ranges.
   task automatic test_sequence_lengths;
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);
      repeat (2) send_byte(8'hBF, 1'b0);
      send_byte(8'hF7, 1'b0);
      repeat (3) send_byte(8'hBF, 1'b0);
      send_byte(8'hFB, 1'b0);
      repeat (4) send_byte(8'h80, 1'b0);
      // Largest code point, completed on the final byte.
      send_byte(8'hFD, 1'b0);
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // Texts that end on a lead byte or in the middle of a sequence.
   task automatic test_cut_short;
      send_byte(8'hC3, 1'b1);
      send_byte(8'hE2, 1'b0);
      // A byte below 0x80 inside a sequence counts as a continuation.
      send_byte(8'h05, 1'b1);
   endtask

   // Narrow mode drops 4-byte and longer sequences but keeps short ones.
   task automatic test_narrow_mode;
      write_wide(1'b0);
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h8F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   // The mode seen at the lead byte holds for the whole sequence.
   task automatic test_mode_change_mid_sequence;
      send_byte(8'hF1, 1'b0);
      write_wide(1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   // Random texts: mostly well-formed sequences, some noise, some cut short.
   task automatic test_random_texts(input logic wide, input logic idle, input int byte_count);
      logic [ByteWidth-1:0] text_bytes[$];
      int                   sent;
      int                   n_chars;
      int                   seq_len;
      int                   cut;
      write_wide(wide);
      idle_on = idle;
      sent    = 0;
      while (sent < byte_count) begin
         text_bytes.delete();
         n_chars = $urandom_range(1, 10);
         for (int c = 0; c < n_chars; c++) begin
            if ($urandom_range(0, 9) == 0) begin
               text_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
               seq_len = $urandom_range(1, 6);
               case (seq_len)
                  1: text_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
                  2: text_bytes.push_back(8'($urandom_range(8'h80, 8'hDF)));
                  3: text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                  4: text_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                  5: text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFB)));
                  default: text_bytes.push_back(8'($urandom_range(8'hFC, 8'hFF)));
               endcase
               for (int k = 1; k < seq_len; k++) begin
                  if ($urandom_range(0, 7) == 0) begin
                     text_bytes.push_back(8'($urandom_range(0, 255)));
                  end else begin
                     text_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
                  end
               end
            end
         end
         // Now and then the text ends in the middle of things.
         if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, text_bytes.size());
            while (text_bytes.size() > cut) void'(text_bytes.pop_back());
         end
         foreach (text_bytes[i]) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
         end
         sent += text_bytes.size();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      test_single_bytes();
      test_sequence_lengths();
      test_cut_short();
      test_narrow_mode();
      test_mode_change_mid_sequence();
      test_random_texts(1'b1, 1'b0, 100);
      test_random_texts(1'b0, 1'b1, 150);
      test_random_texts(1'b1, 1'b1, 150);
      drain();
      if (err_cnt == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
